@@ hw/rtl/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// lr_pkg: shared constants for the line rasteriser
// coordinate width default, gray width, result limit and queue sizing
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_WIDTH_DEF = 7;
    localparam int GRAY_WIDTH      = 4;

    // a line is cut off after this many pixel pairs
    localparam int MAX_RESULTS     = 64;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS);

    // descriptor queue between front and back, power of two
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // extra bits on the signed error term over the coordinate width
    localparam int ERR_EXTRA       = 3;

endpackage

@@ hw/rtl/lr_if.sv @@
// ----------------------------------------------------------------------------
// lr_if: handshake channels of the line rasteriser
// line request channel and pixel pair channel, valid/ready
// ----------------------------------------------------------------------------
interface lr_req_if
    import lr_pkg::*;
    #(parameter int CW = COORD_WIDTH_DEF)
    ();
    logic                  valid;
    logic                  ready;
    logic [CW-1:0]         start_x;
    logic [CW-1:0]         start_y;
    logic [CW-1:0]         end_x;
    logic [CW-1:0]         end_y;
    logic [GRAY_WIDTH-1:0] gray_level;

    modport source (output valid, start_x, start_y, end_x, end_y, gray_level,
                    input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, gray_level,
                    output ready);
endinterface

interface lr_pix_if
    import lr_pkg::*;
    #(parameter int CW = COORD_WIDTH_DEF)
    ();
    logic                  valid;
    logic                  ready;
    logic [CW-1:0]         first_px_x;
    logic [CW-1:0]         first_px_y;
    logic [CW-1:0]         second_px_x;
    logic [CW-1:0]         second_px_y;
    logic                  second_ok;
    logic [GRAY_WIDTH-1:0] pixel_gray;
    logic                  final_pair;

    modport source (output valid, first_px_x, first_px_y, second_px_x, second_px_y,
                    second_ok, pixel_gray, final_pair,
                    input ready);
    modport sink   (input valid, first_px_x, first_px_y, second_px_x, second_px_y,
                    second_ok, pixel_gray, final_pair,
                    output ready);
endinterface

@@ hw/rtl/lr_front.sv @@
// ----------------------------------------------------------------------------
// lr_front: line request intake
// takes a request, derives spans, step directions and the initial error
// ----------------------------------------------------------------------------
module lr_front
    import lr_pkg::*;
    #(
        parameter int CW     = COORD_WIDTH_DEF,
        parameter int DESC_W = 7 * CW + ERR_EXTRA + 2 + GRAY_WIDTH
    )
    (
        lr_req_if.sink             i_req,
        output logic [DESC_W-1:0]  o_desc,
        output logic               o_push,
        input  logic               i_room
    );

    localparam int EW = CW + ERR_EXTRA;

    logic [CW-1:0]        w_span_x;
    logic [CW-1:0]        w_span_y;
    logic                 w_neg_x;
    logic                 w_neg_y;
    logic signed [EW-1:0] w_half_x;
    logic signed [EW-1:0] w_half_y;
    logic signed [EW-1:0] w_err0;

    assign w_neg_x  = !(i_req.start_x < i_req.end_x);
    assign w_neg_y  = !(i_req.start_y < i_req.end_y);
    assign w_span_x = w_neg_x ? (i_req.start_x - i_req.end_x) : (i_req.end_x - i_req.start_x);
    assign w_span_y = w_neg_y ? (i_req.start_y - i_req.end_y) : (i_req.end_y - i_req.start_y);

    // halves truncate, spans are never negative
    assign w_half_x = $signed({{ERR_EXTRA{1'b0}}, 1'b0, w_span_x[CW-1:1]});
    assign w_half_y = $signed({{ERR_EXTRA{1'b0}}, 1'b0, w_span_y[CW-1:1]});
    assign w_err0   = (w_span_x > w_span_y) ? w_half_x : -w_half_y;

    assign o_desc = {i_req.start_x, i_req.start_y, i_req.end_x, i_req.end_y,
                     w_span_x, w_span_y, w_neg_x, w_neg_y, w_err0, i_req.gray_level};

    assign o_push      = i_req.valid;
    assign i_req.ready = i_room;

endmodule

@@ hw/rtl/lr_queue.sv @@
// ----------------------------------------------------------------------------
// lr_queue: short descriptor queue
// decouples request intake from the pixel walk
// ----------------------------------------------------------------------------
module lr_queue
    import lr_pkg::*;
    #(
        parameter int WIDTH = 8
    )
    (
        input  logic             i_clk,
        input  logic             i_rst_n,
        input  logic             i_push,
        input  logic [WIDTH-1:0] i_data,
        output logic             o_room,
        output logic             o_valid,
        output logic [WIDTH-1:0] o_data,
        input  logic             i_pop
    );

    logic [WIDTH-1:0]       r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr;
    logic [QUEUE_PTR_W-1:0] r_rptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   w_wr;
    logic                   w_rd;

    assign o_room  = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && o_room;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/lr_back.sv @@
// ----------------------------------------------------------------------------
// lr_back: pixel walker
// two bresenham steps a cycle while the output is not stalled, one pixel pair per result
// ----------------------------------------------------------------------------
module lr_back
    import lr_pkg::*;
    #(
        parameter int CW     = COORD_WIDTH_DEF,
        parameter int DESC_W = 7 * CW + ERR_EXTRA + 2 + GRAY_WIDTH
    )
    (
        input  logic              i_clk,
        input  logic              i_rst_n,
        input  logic [DESC_W-1:0] i_desc,
        input  logic              i_desc_valid,
        output logic              o_pop,
        lr_pix_if.source          o_pix
    );

    localparam int EW = CW + ERR_EXTRA;

    typedef struct packed {
        logic [CW-1:0]        x;
        logic [CW-1:0]        y;
        logic signed [EW-1:0] e;
    } t_walk;

    function automatic t_walk f_step(t_walk s, logic [CW-1:0] sx, logic [CW-1:0] sy,
                                     logic neg_x, logic neg_y);
        t_walk                r;
        logic signed [EW-1:0] dx;
        logic signed [EW-1:0] dy;
        r  = s;
        dx = $signed({{ERR_EXTRA{1'b0}}, sx});
        dy = $signed({{ERR_EXTRA{1'b0}}, sy});
        if (s.e > -dx) begin
            r.e = r.e - dy;
            r.x = neg_x ? (s.x - 1'b1) : (s.x + 1'b1);
        end
        if (s.e < dy) begin
            r.e = r.e + dx;
            r.y = neg_y ? (s.y - 1'b1) : (s.y + 1'b1);
        end
        return r;
    endfunction

    // descriptor fields
    logic [CW-1:0]         d_x0, d_y0, d_gx, d_gy, d_sx, d_sy;
    logic                  d_nx, d_ny;
    logic signed [EW-1:0]  d_err;
    logic [GRAY_WIDTH-1:0] d_gray;

    assign {d_x0, d_y0, d_gx, d_gy, d_sx, d_sy, d_nx, d_ny, d_err, d_gray} = i_desc;

    // walk state
    logic                  r_busy;
    logic [RES_CNT_W-1:0]  r_cnt;
    t_walk                 r_cur;
    logic [CW-1:0]         r_goal_x, r_goal_y, r_span_x, r_span_y;
    logic                  r_neg_x, r_neg_y;
    logic [GRAY_WIDTH-1:0] r_gray;

    // output register
    logic                  r_out_valid;
    logic [CW-1:0]         r_fx, r_fy, r_sx, r_sy;
    logic                  r_ok, r_final;
    logic [GRAY_WIDTH-1:0] r_out_gray;

    logic  w_load, w_adv, w_at0, w_at1, w_last;
    t_walk w_s1, w_s2;

    assign w_load = !r_busy && i_desc_valid;
    assign o_pop  = w_load;
    assign w_adv  = r_busy && (!r_out_valid || o_pix.ready);

    assign w_s1   = f_step(r_cur, r_span_x, r_span_y, r_neg_x, r_neg_y);
    assign w_s2   = f_step(w_s1, r_span_x, r_span_y, r_neg_x, r_neg_y);
    assign w_at0  = (r_cur.x == r_goal_x) && (r_cur.y == r_goal_y);
    assign w_at1  = (w_s1.x == r_goal_x) && (w_s1.y == r_goal_y);
    // end point reached, or the pair limit cuts the line short
    assign w_last = w_at0 || w_at1 || (r_cnt == RES_CNT_W'(MAX_RESULTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_adv) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur.x  <= d_x0;
            r_cur.y  <= d_y0;
            r_cur.e  <= d_err;
            r_goal_x <= d_gx;
            r_goal_y <= d_gy;
            r_span_x <= d_sx;
            r_span_y <= d_sy;
            r_neg_x  <= d_nx;
            r_neg_y  <= d_ny;
            r_gray   <= d_gray;
        end else if (w_adv) begin
            r_cur <= w_s2;
        end
        if (w_adv) begin
            r_fx       <= r_cur.x;
            r_fy       <= r_cur.y;
            r_ok       <= !w_at0;
            r_sx       <= w_at0 ? '0 : w_s1.x;
            r_sy       <= w_at0 ? '0 : w_s1.y;
            r_out_gray <= r_gray;
            r_final    <= w_last;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.first_px_x  = r_fx;
    assign o_pix.first_px_y  = r_fy;
    assign o_pix.second_px_x = r_sx;
    assign o_pix.second_px_y = r_sy;
    assign o_pix.second_ok   = r_ok;
    assign o_pix.pixel_gray  = r_out_gray;
    assign o_pix.final_pair  = r_final;

endmodule

@@ hw/rtl/line_rasterizer_top.sv @@
// path: a taken line request passes the queue and the walker state into the output
//   register, where its first pixel pair is shown
// throughput: two chained bresenham steps per cycle while the output is not stalled,
//   one pixel pair each; the next line is loaded from the queue after the last pair
// reset: synchronous, active low; clears the queue, the walker and the output
//   register, payload registers are left as they are
// ----------------------------------------------------------------------------
// line_rasterizer_top: bresenham line rasteriser
// accepts line requests and emits the line's pixels two at a time
// ----------------------------------------------------------------------------
module line_rasterizer_top
    import lr_pkg::*;
    #(
        parameter int COORD_WIDTH = COORD_WIDTH_DEF
    )
    (
        input  logic     i_clk,
        input  logic     i_rst_n,
        lr_req_if.sink   i_req,
        lr_pix_if.source o_pix
    );

    // descriptor: endpoints, spans, step signs, initial error and gray level
    localparam int DESC_W = 7 * COORD_WIDTH + ERR_EXTRA + 2 + GRAY_WIDTH;

    logic [DESC_W-1:0] w_push_desc;
    logic              w_push;
    logic              w_room;
    logic [DESC_W-1:0] w_pop_desc;
    logic              w_pop_valid;
    logic              w_pop;

    // front: classify the request and work out the walk set-up
    lr_front #(
        .CW     (COORD_WIDTH),
        .DESC_W (DESC_W)
    ) u_front (
        .i_req  (i_req),
        .o_desc (w_push_desc),
        .o_push (w_push),
        .i_room (w_room)
    );

    // queue: lets the next request in while a line is still being walked
    lr_queue #(
        .WIDTH (DESC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_desc),
        .o_room  (w_room),
        .o_valid (w_pop_valid),
        .o_data  (w_pop_desc),
        .i_pop   (w_pop)
    );

    // back: walk the line and hold each pair in the output register
    lr_back #(
        .CW     (COORD_WIDTH),
        .DESC_W (DESC_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (w_pop_desc),
        .i_desc_valid (w_pop_valid),
        .o_pop        (w_pop),
        .o_pix        (o_pix)
    );

endmodule
